@@ sv/ptd_pkg.sv @@
// ptd_pkg: types, constants and id classification helpers for the TLV deframer.
// Used by ptd_parser, ptd_out_stage and pco_tlv_deframer. No dependencies.
package ptd_pkg;

  // Container ids of the configuration protocols (always one-octet length)
  localparam logic [15:0] IdLcp  = 16'hC021;
  localparam logic [15:0] IdPap  = 16'hC023;
  localparam logic [15:0] IdChap = 16'hC223;
  localparam logic [15:0] IdIpcp = 16'h8021;
  // Additional-parameter ids with a two-octet length on the downlink
  localparam logic [15:0] IdWide0 = 16'h0023;
  localparam logic [15:0] IdWide1 = 16'h0024;
  localparam logic [15:0] IdWide2 = 16'h0030;

  typedef enum logic [2:0] {
    PH_ID_HI   = 3'd0,
    PH_ID_LO   = 3'd1,
    PH_LEN_HI  = 3'd2,
    PH_LEN_LO  = 3'd3,
    PH_CONTENT = 3'd4
  } ptd_phase_e;

  typedef struct packed {
    logic [15:0] container_id;
    logic        is_protocol;
    logic        has_data;
    logic [7:0]  content_byte;
    logic        last_of_container;
    logic        truncated;
  } ptd_result_t;

  function automatic logic id_is_protocol(input logic [15:0] id);
    return (id == IdLcp) || (id == IdPap) || (id == IdChap) || (id == IdIpcp);
  endfunction

  function automatic logic id_has_wide_length(input logic [15:0] id, input logic uplink);
    return !uplink && ((id == IdWide0) || (id == IdWide1) || (id == IdWide2));
  endfunction

endpackage

@@ sv/ptd_if.sv @@
// ptd_if: valid/ready channel interfaces for the TLV deframer input and result words.
// Standalone; no package dependency.
interface ptd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, data_byte, end_of_buffer, input ready);
  modport sink   (input valid, data_byte, end_of_buffer, output ready);
endinterface

interface ptd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] container_id;
  logic        is_protocol;
  logic        has_data;
  logic [7:0]  content_byte;
  logic        last_of_container;
  logic        truncated;

  modport source (output valid, container_id, is_protocol, has_data, content_byte,
                  last_of_container, truncated, input ready);
  modport sink   (input valid, container_id, is_protocol, has_data, content_byte,
                  last_of_container, truncated, output ready);
endinterface

@@ sv/pco_tlv_deframer.sv @@
// pco_tlv_deframer: top level of the protocol configuration option TLV deframer.
// Depends on ptd_pkg, ptd_if, ptd_parser and ptd_out_stage.
//
// Usage:
//  - in_i carries one octet of the options buffer per word, with end_of_buffer
//    set on the final octet. out_o carries one result word per content octet,
//    one per empty container, and one per container cut short by the buffer.
//  - Header octets (id and length) normally give no result word.
//  - cfg_we_i / cfg_wdata_i write uplink_direction; write only while idle.
//    The length width is chosen when the id completes.
// Data path: an input word lands in the input register and is parsed from there
//  into the result register, which drives out_o.
// Throughput: 1 word per cycle unless out_o stalls a result-making word; the
//  phase machine and 16-bit length counter advance once per octet.
// Reset: parser returns to "expect id high octet", id and length clear,
//  uplink_direction = 0, both registers empty.
// Stall: while out_o is held, a word that makes a result waits in the input
//  register; header words still pass through. in_i.ready drops only when the
//  input register holds a result-making word and the result register is full.
module pco_tlv_deframer
  import ptd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  ptd_in_if.sink    in_i,
  ptd_out_if.source out_o
);

  logic        uplink_q;

  // input register
  logic        s0_valid_q;
  logic [7:0]  s0_byte_q;
  logic        s0_eob_q;

  logic        emit;
  ptd_result_t result;
  logic        out_free;
  logic        s0_adv;
  logic        in_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      uplink_q <= 1'b0;
    end else if (cfg_we_i) begin
      uplink_q <= cfg_wdata_i;
    end
  end

  // word leaves the input register unless its result has nowhere to go
  assign s0_adv     = s0_valid_q && (!emit || out_free);
  assign in_i.ready = !s0_valid_q || s0_adv;
  assign in_take    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (in_take) begin
      s0_valid_q <= 1'b1;
    end else if (s0_adv) begin
      s0_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s0_byte_q <= in_i.data_byte;
      s0_eob_q  <= in_i.end_of_buffer;
    end
  end

  ptd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .uplink_i    (uplink_q),
    .step_i      (s0_adv),
    .data_byte_i (s0_byte_q),
    .eob_i       (s0_eob_q),
    .emit_o      (emit),
    .result_o    (result)
  );

  ptd_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (s0_adv && emit),
    .result_i (result),
    .free_o   (out_free),
    .out_o    (out_o)
  );

  // a drained result register empties unless refilled in the same cycle
  a_out_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && !(s0_adv && emit)) |=> !out_o.valid)
    else $error("result register did not drain");

  // a truncated result always closes its container
  a_trunc_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.truncated) |-> out_o.last_of_container)
    else $error("truncated result without last mark");

  // empty or header results carry a zero content octet
  a_no_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.has_data) |-> (out_o.content_byte == 8'h00))
    else $error("content octet set without data");

  // a result word never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |-> !(s0_adv && emit))
    else $error("result overwritten while stalled");

endmodule

@@ sv/ptd_parser.sv @@
// ptd_parser: container phase machine, id and length counter; one octet per step.
// Depends on ptd_pkg.
module ptd_parser
  import ptd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        uplink_i,
  input  logic        step_i,
  input  logic [7:0]  data_byte_i,
  input  logic        eob_i,
  output logic        emit_o,
  output ptd_result_t result_o
);

  ptd_phase_e  phase_q, phase_d;
  logic [15:0] id_q, id_d;
  logic [15:0] rem_q, rem_d;
  logic        wide;
  logic        rem_zero;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_ID_HI;
      id_q    <= '0;
      rem_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      id_q    <= id_d;
      rem_q   <= rem_d;
    end
  end

  // next state
  always_comb begin
    phase_d = PH_ID_HI;
    id_d    = id_q;
    rem_d   = rem_q;
    wide    = 1'b0;
    unique case (phase_q)
      PH_ID_HI: begin
        id_d    = {data_byte_i, 8'h00};
        phase_d = eob_i ? PH_ID_HI : PH_ID_LO;
      end
      PH_ID_LO: begin
        id_d    = {id_q[15:8], data_byte_i};
        wide    = !id_is_protocol(id_d) && id_has_wide_length(id_d, uplink_i);
        rem_d   = '0;
        phase_d = eob_i ? PH_ID_HI : (wide ? PH_LEN_HI : PH_LEN_LO);
      end
      PH_LEN_HI: begin
        rem_d   = {data_byte_i, 8'h00};
        phase_d = eob_i ? PH_ID_HI : PH_LEN_LO;
      end
      PH_LEN_LO: begin
        rem_d   = {rem_q[15:8], data_byte_i};
        phase_d = ((rem_d == '0) || eob_i) ? PH_ID_HI : PH_CONTENT;
      end
      PH_CONTENT: begin
        rem_d   = rem_q - 16'd1;
        phase_d = ((rem_d == '0) || eob_i) ? PH_ID_HI : PH_CONTENT;
      end
      default: phase_d = PH_ID_HI;
    endcase
  end

  assign rem_zero = (rem_d == '0);

  // result word
  always_comb begin
    emit_o                     = 1'b0;
    result_o.container_id      = id_d;
    result_o.is_protocol       = (phase_q != PH_ID_HI) && id_is_protocol(id_d);
    result_o.has_data          = 1'b0;
    result_o.content_byte      = 8'h00;
    result_o.last_of_container = 1'b1;
    result_o.truncated         = 1'b1;
    unique case (phase_q)
      PH_ID_HI, PH_ID_LO, PH_LEN_HI: emit_o = eob_i;
      PH_LEN_LO: begin
        emit_o             = rem_zero || eob_i;
        result_o.truncated = !rem_zero;
      end
      PH_CONTENT: begin
        emit_o                     = 1'b1;
        result_o.has_data          = 1'b1;
        result_o.content_byte      = data_byte_i;
        result_o.last_of_container = rem_zero || eob_i;
        result_o.truncated         = !rem_zero && eob_i;
      end
      default: emit_o = 1'b0;
    endcase
  end

endmodule

@@ sv/ptd_out_stage.sv @@
// ptd_out_stage: result register driving the output channel.
// Depends on ptd_pkg and ptd_out_if.
module ptd_out_stage
  import ptd_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  ptd_result_t     result_i,
  output logic            free_o,
  ptd_out_if.source       out_o
);

  logic        valid_q;
  ptd_result_t res_q;

  // slot can take a word if empty or being drained this cycle
  assign free_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign out_o.valid             = valid_q;
  assign out_o.container_id      = res_q.container_id;
  assign out_o.is_protocol       = res_q.is_protocol;
  assign out_o.has_data          = res_q.has_data;
  assign out_o.content_byte      = res_q.content_byte;
  assign out_o.last_of_container = res_q.last_of_container;
  assign out_o.truncated         = res_q.truncated;

endmodule
